/* rtl/pnh_pkg.sv */
// Shared types and constants for the pixel mean/scale to half-precision block.
package pnh_pkg;

	localparam int PIX_W     = 8;
	localparam int MEAN_W    = 16;
	localparam int GAIN_W    = 24;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;
	localparam int DIFF_W    = MEAN_W + 1;
	localparam int MAG_W     = MEAN_W + GAIN_W;
	localparam int TOP_W     = 6;
	localparam int HALF_W    = 16;
	localparam int EXP_W     = 5;
	localparam int MANT_W    = 10;
	localparam int FRAC_BITS = 24;
	localparam int EXP_BIAS  = 15;
	localparam int MIN_TOP   = FRAC_BITS - 14;
	localparam int OVF_TOP   = FRAC_BITS + 16;

	localparam logic [HALF_W-2:0] HALF_MAX_FINITE = 15'h7bff;
	localparam logic [GAIN_W-1:0] GAIN_RESET      = 24'h010000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MEAN_RED   = 2'd0,
		CFG_MEAN_GREEN = 2'd1,
		CFG_MEAN_BLUE  = 2'd2,
		CFG_GAIN       = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

/* rtl/pnh_ctrl.sv */
// Valid pipeline and per-stage load enables shared by all channel lanes.
module pnh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output pnh_pkg::stage_en_t  en
);
	import pnh_pkg::*;

	logic v_s1;
	logic v_s2;
	logic v_s3;

	always_comb begin
		en.s3 = !v_s3 || out_ready;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign in_ready  = en.s1;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en.s1) begin
				v_s1 <= in_valid;
			end
			if (en.s2) begin
				v_s2 <= v_s1;
			end
			if (en.s3) begin
				v_s3 <= v_s2;
			end
		end
	end

`ifndef ASSERT_OFF
	a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && !out_ready))
		else $error("input stalled while pipeline has room");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted item lost at stage 1");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && en.s2) |=> v_s2)
		else $error("item lost between stage 1 and stage 2");
`endif

endmodule

/* rtl/pnh_lane.sv */
// One channel lane: mean subtract and gain multiply, leading-one search, half packing.
module pnh_lane (
	input  logic                          clk,
	input  pnh_pkg::stage_en_t            en,
	input  logic [pnh_pkg::PIX_W-1:0]     pix,
	input  logic [pnh_pkg::MEAN_W-1:0]    mean,
	input  logic [pnh_pkg::GAIN_W-1:0]    gain,
	output logic [pnh_pkg::HALF_W-1:0]    half
);
	import pnh_pkg::*;

	logic [DIFF_W-1:0]  diff;
	logic               neg;
	logic [MEAN_W-1:0]  absd;
	logic [TOP_W-1:0]   top;

	logic [MAG_W-1:0]   mag_s1;
	logic               neg_s1;
	logic [MAG_W-1:0]   mag_s2;
	logic               neg_s2;
	logic               nz_s2;
	logic [TOP_W-1:0]   top_s2;
	logic [HALF_W-1:0]  half_s3;

	logic [EXP_W-1:0]   expo;
	logic [TOP_W-1:0]   shamt;
	logic [MAG_W-1:0]   shifted;
	logic [HALF_W-1:0]  packed_half;

	always_comb begin
		diff = {1'b0, pix, 8'b0} - {1'b0, mean};
		neg  = diff[DIFF_W-1];
		absd = neg ? MEAN_W'(-diff) : diff[MEAN_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			mag_s1 <= MAG_W'(absd) * MAG_W'(gain);
			neg_s1 <= neg;
		end
	end

	always_comb begin
		top = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (mag_s1[i]) begin
				top = TOP_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			nz_s2  <= |mag_s1;
			top_s2 <= top;
		end
	end

	always_comb begin
		expo    = EXP_W'(top_s2 - TOP_W'(FRAC_BITS - EXP_BIAS));
		shamt   = top_s2 - TOP_W'(MANT_W);
		shifted = mag_s2 >> shamt;
		priority if (!nz_s2) begin
			packed_half = '0;
		end else if (top_s2 < TOP_W'(MIN_TOP)) begin
			packed_half = {neg_s2, {(HALF_W-1){1'b0}}};
		end else if (top_s2 >= TOP_W'(OVF_TOP)) begin
			packed_half = {neg_s2, HALF_MAX_FINITE};
		end else begin
			packed_half = {neg_s2, expo, shifted[MANT_W-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			half_s3 <= packed_half;
		end
	end

	assign half = half_s3;

endmodule

/* rtl/pixel_normalize_to_half.sv */
// Top level: BGR pixel mean/scale normalization to three IEEE half words.
//
// Input channel: in_valid/in_ready carry one pixel (pixel_blue, pixel_green,
// pixel_red). Output channel: out_valid/out_ready carry half_red, half_green
// and half_blue of the same pixel as one item.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 mean_red,
// 1 mean_green, 2 mean_blue, 3 gain). Write only while no item is in flight.
// Path: each item passes the multiply, leading-one search and pack/output
// registers in turn before out_valid rises. Throughput: one pixel per cycle
// unless out_ready stalls the output; the three channel lanes run side by
// side, each a three-stage pipeline.
// Reset: means clear to 0, gain returns to 1.0, the pipeline empties.
// Stall: while out_ready is low the held result stays; the stages behind it
// keep filling bubbles, and in_ready falls only once all three are full.
module pixel_normalize_to_half (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pnh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pnh_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pnh_pkg::PIX_W-1:0]         pixel_blue,
	input  logic [pnh_pkg::PIX_W-1:0]         pixel_green,
	input  logic [pnh_pkg::PIX_W-1:0]         pixel_red,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pnh_pkg::HALF_W-1:0]        half_red,
	output logic [pnh_pkg::HALF_W-1:0]        half_green,
	output logic [pnh_pkg::HALF_W-1:0]        half_blue
);
	import pnh_pkg::*;

	logic [MEAN_W-1:0] mean_red_q;
	logic [MEAN_W-1:0] mean_green_q;
	logic [MEAN_W-1:0] mean_blue_q;
	logic [GAIN_W-1:0] gain_q;
	cfg_idx_t          idx;
	stage_en_t         en;

	assign idx = cfg_idx_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_red_q   <= '0;
			mean_green_q <= '0;
			mean_blue_q  <= '0;
			gain_q       <= GAIN_RESET;
		end else if (cfg_we) begin
			unique case (idx)
				CFG_MEAN_RED:   mean_red_q   <= cfg_data[MEAN_W-1:0];
				CFG_MEAN_GREEN: mean_green_q <= cfg_data[MEAN_W-1:0];
				CFG_MEAN_BLUE:  mean_blue_q  <= cfg_data[MEAN_W-1:0];
				CFG_GAIN:       gain_q       <= cfg_data[GAIN_W-1:0];
			endcase
		end
	end

	pnh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.en        (en)
	);

	pnh_lane u_lane_red (
		.clk  (clk),
		.en   (en),
		.pix  (pixel_red),
		.mean (mean_red_q),
		.gain (gain_q),
		.half (half_red)
	);

	pnh_lane u_lane_green (
		.clk  (clk),
		.en   (en),
		.pix  (pixel_green),
		.mean (mean_green_q),
		.gain (gain_q),
		.half (half_green)
	);

	pnh_lane u_lane_blue (
		.clk  (clk),
		.en   (en),
		.pix  (pixel_blue),
		.mean (mean_blue_q),
		.gain (gain_q),
		.half (half_blue)
	);

`ifndef ASSERT_OFF
	a_gain_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> (gain_q == GAIN_RESET))
		else $error("gain not at unity after reset");

	a_cfg_gain_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && idx == CFG_GAIN) |=> (gain_q == $past(cfg_data)))
		else $error("gain write not taken");

	a_cfg_mean_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> $stable(mean_red_q) && $stable(mean_green_q) && $stable(mean_blue_q))
		else $error("mean changed without a write");
`endif

endmodule

/* sim/pixel_normalize_to_half_tb.sv */
// Testbench for pixel_normalize_to_half: BGR pixels against a mean/gain-to-half predictor.
module pixel_normalize_to_half_tb;
	import pnh_pkg::*;

	localparam int LATENCY    = 3;
	localparam int WATCHDOG   = 5000;
	localparam int RAND_ITEMS = 67;

	typedef struct {
		logic [HALF_W-1:0] red;
		logic [HALF_W-1:0] green;
		logic [HALF_W-1:0] blue;
	} halves_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_MEAN_RED;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [PIX_W-1:0]     pixel_blue = '0;
	logic [PIX_W-1:0]     pixel_green = '0;
	logic [PIX_W-1:0]     pixel_red = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [HALF_W-1:0]    half_red;
	logic [HALF_W-1:0]    half_green;
	logic [HALF_W-1:0]    half_blue;

	logic [MEAN_W-1:0] mean_r = '0;
	logic [MEAN_W-1:0] mean_g = '0;
	logic [MEAN_W-1:0] mean_b = '0;
	logic [GAIN_W-1:0] gain_q = GAIN_RESET;

	halves_t expected_halves[$];
	int      mismatch_count = 0;
	int      send_idle_pct = 0;
	int      stall_pct = 0;
	int      quiet_cycles = 0;

	pixel_normalize_to_half dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_blue (pixel_blue),
		.pixel_green(pixel_green),
		.pixel_red  (pixel_red),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.half_red   (half_red),
		.half_green (half_green),
		.half_blue  (half_blue)
	);

	always #2 clk = ~clk;

	function automatic logic [HALF_W-1:0] predict_half(logic [PIX_W-1:0] px,
			logic [MEAN_W-1:0] mean, logic [GAIN_W-1:0] g);
		logic signed [DIFF_W:0] diff;
		logic [DIFF_W-1:0]      abs_diff;
		logic [MAG_W:0]         mag;
		logic                   sgn;
		logic [MANT_W-1:0]      mant;
		int                     top;
		int                     exp_val;
		diff = $signed({2'b00, px, 8'h00}) - $signed({2'b00, mean});
		sgn = diff < 0;
		abs_diff = sgn ? DIFF_W'(-diff) : DIFF_W'(diff);
		mag = abs_diff * g;
		if (mag == 0)
			return '0;
		top = 0;
		for (int i = 0; i <= MAG_W; i++)
			if (mag[i])
				top = i;
		exp_val = top - FRAC_BITS;
		if (exp_val < -14)
			return {sgn, 15'd0};
		if (exp_val >= 16)
			return {sgn, HALF_MAX_FINITE};
		mant = MANT_W'(mag >> (top - MANT_W));
		return {sgn, EXP_W'(exp_val + EXP_BIAS), mant};
	endfunction

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk)
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;

	always @(posedge clk) begin
		halves_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_halves.size() == 0) begin
				$error("unexpected item: red %h green %h blue %h",
					half_red, half_green, half_blue);
				mismatch_count++;
			end else begin
				want = expected_halves.pop_front();
				if (half_red !== want.red) begin
					$error("half_red: expected %h actual %h", want.red, half_red);
					mismatch_count++;
				end
				if (half_green !== want.green) begin
					$error("half_green: expected %h actual %h", want.green, half_green);
					mismatch_count++;
				end
				if (half_blue !== want.blue) begin
					$error("half_blue: expected %h actual %h", want.blue, half_blue);
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_pixel(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g, logic [PIX_W-1:0] r);
		halves_t exp_item;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_blue <= b;
		pixel_green <= g;
		pixel_red <= r;
		do
			@(posedge clk);
		while (!in_ready);
		exp_item.red = predict_half(r, mean_r, gain_q);
		exp_item.green = predict_half(g, mean_g, gain_q);
		exp_item.blue = predict_half(b, mean_b, gain_q);
		expected_halves.insert(expected_halves.size(), exp_item);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_halves.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_MEAN_RED:   mean_r = data[MEAN_W-1:0];
			CFG_MEAN_GREEN: mean_g = data[MEAN_W-1:0];
			CFG_MEAN_BLUE:  mean_b = data[MEAN_W-1:0];
			CFG_GAIN:       gain_q = data[GAIN_W-1:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(logic [CFG_W-1:0] mr, logic [CFG_W-1:0] mg,
			logic [CFG_W-1:0] mb, logic [CFG_W-1:0] g);
		wait_idle();
		write_reg(CFG_MEAN_RED, mr);
		write_reg(CFG_MEAN_GREEN, mg);
		write_reg(CFG_MEAN_BLUE, mb);
		write_reg(CFG_GAIN, g);
	endtask

	function automatic logic [CFG_W-1:0] pick_mean();
		case ($urandom_range(3))
			0:       return '0;
			1:       return 24'h00ffff;
			default: return CFG_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_gain();
		case ($urandom_range(5))
			0:       return 24'hffffff;
			1:       return CFG_W'($urandom_range(16'hffff));
			2:       return CFG_W'($urandom_range(1023));
			3:       return GAIN_RESET;
			default: return CFG_W'($urandom);
		endcase
	endfunction

	// bias toward bytes near the mean to reach exact zero and tiny magnitudes
	function automatic logic [PIX_W-1:0] pick_byte(logic [MEAN_W-1:0] mean);
		if ($urandom_range(3) == 0)
			return PIX_W'(mean[15:8] + $urandom_range(1));
		return PIX_W'($urandom);
	endfunction

	task automatic test_reset_defaults();
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hff, 8'hff, 8'hff);
		send_pixel(8'h01, 8'h80, 8'h02);
	endtask

	task automatic test_extremes();
		write_all(24'h00ffff, 24'h00ffff, 24'h00ffff, 24'hffffff);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hff, 8'hff, 8'hff);
		write_all(24'h000000, 24'h000000, 24'h000000, 24'hffffff);
		send_pixel(8'hff, 8'h00, 8'haa);
		send_pixel(8'h55, 8'hfe, 8'h01);
		write_all(24'h001234, 24'h00fedc, 24'h000000, 24'h000000);
		send_pixel(8'hff, 8'h00, 8'h12);
	endtask

	task automatic test_zero_and_tiny();
		// upper data bits above the mean width must be dropped
		write_all(24'hff8000, 24'h008001, 24'h007fff, GAIN_RESET);
		send_pixel(8'h80, 8'h80, 8'h80);
		send_pixel(8'h7f, 8'h81, 8'h80);
		write_all(24'h008000, 24'h008001, 24'h007fff, 24'h000400);
		send_pixel(8'h80, 8'h80, 8'h80);
		write_all(24'h008001, 24'h008001, 24'h007fff, 24'h0003ff);
		send_pixel(8'h80, 8'h80, 8'h80);
		send_pixel(8'h00, 8'hff, 8'h81);
		write_all(24'h000100, 24'h000300, 24'h00fe00, 24'h000001);
		send_pixel(8'hfe, 8'h02, 8'h01);
	endtask

	task automatic test_random();
		int send_pcts[4] = '{0, 87, 0, 9};
		int stall_pcts[4] = '{0, 0, 87, 9};
		for (int mode = 0; mode < 4; mode++) begin
			send_idle_pct = send_pcts[mode];
			stall_pct = stall_pcts[mode];
			repeat (2) begin
				write_all(pick_mean(), pick_mean(), pick_mean(), pick_gain());
				repeat (RAND_ITEMS)
					send_pixel(pick_byte(mean_b), pick_byte(mean_g), pick_byte(mean_r));
			end
		end
	endtask

	initial begin
		while (quiet_cycles < WATCHDOG)
			@(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_extremes();
		test_zero_and_tiny();
		test_random();
		wait_idle();
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
